@@ rtl/ray_parallelogram_intersect_unit_macros.svh @@
// Assertion macros shared by the checker of the ray/parallelogram intersect unit.
`ifndef RAY_PARALLELOGRAM_INTERSECT_UNIT_MACROS_SVH
`define RAY_PARALLELOGRAM_INTERSECT_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define RPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rpi_pkg.sv @@
// Package of the ray/parallelogram intersect unit: register codes and fixed constants.
`timescale 1ns / 1ps
package rpi_pkg;

  // Configuration register width and index codes.
  localparam int REG_W = 63;
  localparam int MAT_W = 8;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CORNER   = 3'd0,
    REG_EDGE_U   = 3'd1,
    REG_EDGE_V   = 3'd2,
    REG_NORMAL   = 3'd3,
    REG_MATERIAL = 3'd4
  } reg_idx_t;

  // 1e-8 = 1 / 10^8, and 1e-12 * 2^12 = 1 / 5^12.
  localparam longint unsigned PAR_DIVISOR = 64'd100000000;
  localparam longint unsigned DET_DIVISOR = 64'd244140625;

  // ceil(2^k / m) for m > 1 by shift-and-subtract; elaboration only.
  function automatic longint unsigned ceil_pow2_div(int k, longint unsigned m);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 1;
    for (int i = 0; i < k; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= m) begin
        q = q | 64'd1;
        r = r - m;
      end
    end
    return q + ((r != 0) ? 64'd1 : 64'd0);
  endfunction

endpackage

@@ rtl/ray_parallelogram_intersect_unit.sv @@
// Ray/parallelogram intersect top: deep pipeline, one ray per cycle unless stalled.
`timescale 1ns / 1ps
// Tests each ray (origin, direction, t range) against one parallelogram held in
// configuration registers and returns one result item per ray: hit flag in m_tuser,
// and t, the saturated hit point, the normal turned to face the ray and the material
// tag in m_tdata (all zero on a miss). The unit takes one item every cycle while the
// output is not stalled; most of its depth is the restoring divider for t, which
// resolves one quotient bit per stage, followed by split 2x2 Gram multiplies for the
// edge test. All stages advance together; the pipeline holds only while a finished
// item waits at the output, so s_tready drops only then. Gram terms and the determinant
// are worked out from the registers in a free-running side pipeline (products, sums,
// partial products, joined products, determinant). Write the registers only while no
// item is in flight; register indexes beyond the list are ignored.
module ray_parallelogram_intersect_unit
  import rpi_pkg::*;
#(
  parameter int COORD_WIDTH      = 21,
  parameter int COORD_FRAC_BITS  = 10,
  parameter int NORMAL_FRAC_BITS = 19
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // hit_t, point_x, point_y, point_z, facing_nx, facing_ny, facing_nz, hit_material
  output logic [((7*COORD_WIDTH+MAT_W+7)/8)*8-1:0]    m_tdata,
  // hit
  output logic [0:0]                                  m_tuser,
  input  logic                                        cfg_we,
  input  logic [IDX_W-1:0]                            cfg_index,
  input  logic [REG_W-1:0]                            cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = COORD_FRAC_BITS;
  localparam int DIN_W  = ((8*CW+7)/8)*8;
  localparam int DOUT_W = ((7*CW+MAT_W+7)/8)*8;
  localparam int XW     = (3*CW > REG_W) ? 3*CW : REG_W;

  // Widths of the intermediate terms.
  localparam int PRD_W = 2*CW;
  localparam int DEN_W = 2*CW+2;
  localparam int CO_W  = CW+1;
  localparam int PN_W  = 2*CW+1;
  localparam int NUM_W = 2*CW+3;
  localparam int NSH_W = NUM_W+F+1;
  localparam int BW    = ((NSH_W > DEN_W+CW) ? NSH_W : DEN_W+CW) + 1;
  localparam int RW    = DEN_W+CW;
  localparam int P_W   = ((2*CW-F > CW) ? 2*CW-F : CW) + 1;
  localparam int W_W   = P_W+1;
  localparam int WP_W  = W_W+CW;
  localparam int WG_W  = WP_W+2;
  localparam int G_W   = 2*CW+2;
  localparam int LA    = G_W/2;
  localparam int LB    = WG_W/2;
  localparam int HH_W  = (G_W-LA)+(WG_W-LB);
  localparam int HL_W  = (G_W-LA)+(LB+1);
  localparam int LH_W  = (LA+1)+(WG_W-LB);
  localparam int LL_W  = (LA+1)+(LB+1);
  localparam int PPW   = HH_W+2;
  localparam int PR_W  = G_W+WG_W;
  localparam int NA_W  = PR_W+1;

  // Stage numbers; the divider takes CW stages after the overflow check.
  localparam int ST_PROD = 1;
  localparam int ST_DEN  = 2;
  localparam int ST_NUM  = 3;
  localparam int ST_NEG  = 4;
  localparam int ST_BIAS = 5;
  localparam int ST_OVF  = 6;
  localparam int ST_DIVL = ST_OVF+CW;
  localparam int ST_RNG  = ST_DIVL+1;
  localparam int ST_PNT  = ST_DIVL+2;
  localparam int ST_WV   = ST_DIVL+3;
  localparam int ST_WPR  = ST_DIVL+4;
  localparam int ST_WSUM = ST_DIVL+5;
  localparam int ST_PP   = ST_DIVL+6;
  localparam int ST_FULL = ST_DIVL+7;
  localparam int ST_SUB  = ST_DIVL+8;
  localparam int ST_NORM = ST_DIVL+9;
  localparam int NS      = ST_DIVL+10;

  localparam longint unsigned DEN_THR =
    ceil_pow2_div(NORMAL_FRAC_BITS+COORD_FRAC_BITS, PAR_DIVISOR);
  localparam longint unsigned DET_THR = ceil_pow2_div(4*COORD_FRAC_BITS-12, DET_DIVISOR);
  localparam logic [DEN_W-1:0]        DEN_LIM = DEN_W'(DEN_THR);
  localparam logic signed [NA_W-1:0]  DET_LIM = NA_W'(DET_THR);
  localparam logic signed [CW-1:0]    C_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]    C_MIN   = {1'b1, {(CW-1){1'b0}}};

  // Fields that ride along with every item.
  typedef struct packed {
    logic                    miss;
    logic                    dpos;
    logic [2:0][CW-1:0]      o;
    logic [2:0][CW-1:0]      d;
    logic [CW-1:0]           tmin;
    logic [CW-1:0]           tmax;
    logic [CW-1:0]           t;
    logic [2:0][P_W-1:0]     p;
  } carry_t;

  // ---------------------------------------------------------------- registers
  logic [REG_W-1:0] corner, edge_u, edge_v, normal;
  logic [MAT_W-1:0] material;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner   <= '0;
      edge_u   <= '0;
      edge_v   <= '0;
      normal   <= '0;
      material <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORNER:   corner   <= cfg_data;
        REG_EDGE_U:   edge_u   <= cfg_data;
        REG_EDGE_V:   edge_v   <= cfg_data;
        REG_NORMAL:   normal   <= cfg_data;
        REG_MATERIAL: material <= cfg_data[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the vectors; bits above the register read as zero.
  logic [XW-1:0] corner_x, edge_u_x, edge_v_x, normal_x;
  logic signed [CW-1:0] cc [3];
  logic signed [CW-1:0] uc [3];
  logic signed [CW-1:0] vc [3];
  logic signed [CW-1:0] nc [3];

  assign corner_x = XW'(corner);
  assign edge_u_x = XW'(edge_u);
  assign edge_v_x = XW'(edge_v);
  assign normal_x = XW'(normal);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc[k] = $signed(corner_x[k*CW +: CW]);
      uc[k] = $signed(edge_u_x[k*CW +: CW]);
      vc[k] = $signed(edge_v_x[k*CW +: CW]);
      nc[k] = $signed(normal_x[k*CW +: CW]);
    end
  end

  // ---------------------------------------------------------------- split multiply
  // Four partial products of the operand halves; joined one stage later.
  function automatic logic [4*PPW-1:0] split_mul(logic signed [G_W-1:0] a,
                                                  logic signed [WG_W-1:0] b);
    logic signed [G_W-LA-1:0]  ah;
    logic        [LA-1:0]      al;
    logic signed [WG_W-LB-1:0] bh;
    logic        [LB-1:0]      bl;
    logic signed [HH_W-1:0]    hh;
    logic signed [HL_W-1:0]    hl;
    logic signed [LH_W-1:0]    lh;
    logic signed [LL_W-1:0]    ll;
    ah = a[G_W-1:LA];
    al = a[LA-1:0];
    bh = b[WG_W-1:LB];
    bl = b[LB-1:0];
    hh = ah * bh;
    hl = ah * $signed({1'b0, bl});
    lh = $signed({1'b0, al}) * bh;
    ll = $signed({1'b0, al}) * $signed({1'b0, bl});
    return {PPW'(hh), PPW'(hl), PPW'(lh), PPW'(ll)};
  endfunction

  function automatic logic signed [PR_W-1:0] join_pp(logic [4*PPW-1:0] pp);
    logic signed [PPW-1:0] hh, hl, lh, ll;
    hh = $signed(pp[4*PPW-1 -: PPW]);
    hl = $signed(pp[3*PPW-1 -: PPW]);
    lh = $signed(pp[2*PPW-1 -: PPW]);
    ll = $signed(pp[PPW-1:0]);
    return (PR_W'(hh) <<< (LA+LB)) + (PR_W'(hl) <<< LA) + (PR_W'(lh) <<< LB) + PR_W'(ll);
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(logic signed [P_W-1:0] v);
    if (v > P_W'(C_MAX)) return C_MAX;
    if (v < P_W'(C_MIN)) return C_MIN;
    return CW'(v);
  endfunction

  // ---------------------------------------------------------------- Gram side pipeline
  // Free running: registers for products, sums, partial products, joins and determinant.
  logic signed [PRD_W-1:0] guu [3];
  logic signed [PRD_W-1:0] guv [3];
  logic signed [PRD_W-1:0] gvv [3];
  logic signed [G_W-1:0]   uu, uv, vv;
  logic [4*PPW-1:0]        det_pp [2];
  logic signed [PR_W-1:0]  det_pr [2];
  logic signed [NA_W-1:0]  det_cfg;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      guu[k] <= uc[k] * uc[k];
      guv[k] <= uc[k] * vc[k];
      gvv[k] <= vc[k] * vc[k];
    end
    uu <= G_W'(guu[0]) + G_W'(guu[1]) + G_W'(guu[2]);
    uv <= G_W'(guv[0]) + G_W'(guv[1]) + G_W'(guv[2]);
    vv <= G_W'(gvv[0]) + G_W'(gvv[1]) + G_W'(gvv[2]);
    det_pp[0] <= split_mul(uv, WG_W'(uv));
    det_pp[1] <= split_mul(uu, WG_W'(vv));
    det_pr[0] <= join_pp(det_pp[0]);
    det_pr[1] <= join_pp(det_pp[1]);
    det_cfg   <= NA_W'(det_pr[0]) - NA_W'(det_pr[1]);
  end

  // ---------------------------------------------------------------- item pipeline
  logic [NS:0] vld;
  carry_t      cq [NS+1];
  carry_t      cn [NS+1];
  logic        en;

  // Advance everything unless the output holds an item nobody takes.
  assign en       = !vld[NS] || m_tready;
  assign s_tready = en;

  always_comb begin
    cq[0]      = '0;
    cq[0].o    = s_tdata[3*CW-1:0];
    cq[0].d    = s_tdata[6*CW-1:3*CW];
    cq[0].tmin = s_tdata[7*CW-1:6*CW];
    cq[0].tmax = s_tdata[8*CW-1:7*CW];
  end

  assign vld[0] = s_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NS:1] <= '0;
    end else if (en) begin
      vld[NS:1] <= vld[NS-1:0];
    end
  end

  // Stage registers of the arithmetic.
  logic signed [PRD_W-1:0] pd [3];
  logic signed [CO_W-1:0]  co [3];
  logic signed [DEN_W-1:0] den;
  logic signed [PN_W-1:0]  pn [3];
  logic signed [NUM_W-1:0] num;
  logic                    dneg;
  logic signed [NSH_W-1:0] nsh;
  logic signed [BW-1:0]    bias;
  logic [DEN_W-1:0]        dv  [ST_NUM:ST_DIVL];
  logic [RW-1:0]           rem [ST_OVF:ST_DIVL];
  logic [CW-1:0]           quo [ST_OVF:ST_DIVL];
  logic signed [PRD_W-1:0] td [3];
  logic signed [W_W-1:0]   wvec [3];
  logic signed [WP_W-1:0]  wup [3];
  logic signed [WP_W-1:0]  wvp [3];
  logic signed [WG_W-1:0]  wu, wv;
  logic [4*PPW-1:0]        ipp [4];
  logic signed [PR_W-1:0]  ipr [4];
  logic signed [NA_W-1:0]  na, nb, det;
  logic signed [NA_W-1:0]  na_n, nb_n, det_n;

  // Combinational helpers at the stages that update the carried fields.
  logic [DEN_W-1:0]      dabs_c;
  logic signed [BW-1:0]  dlim_c;
  logic                  ovf_c;
  logic signed [CW-1:0]  t_c;
  logic                  fmiss_c;

  assign dabs_c  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign dlim_c  = BW'($signed({1'b0, dv[ST_BIAS]})) <<< CW;
  assign ovf_c   = bias[BW-1] || (bias >= dlim_c);
  // Offset quotient back to signed: subtract half the range.
  assign t_c     = $signed({~quo[ST_DIVL][CW-1], quo[ST_DIVL][CW-2:0]});
  assign fmiss_c = cq[ST_NORM].miss || (det_n < DET_LIM) || na_n[NA_W-1] || nb_n[NA_W-1]
                   || (na_n > det_n) || (nb_n > det_n);

  always_comb begin
    for (int s = 1; s <= NS; s++) cn[s] = cq[s-1];
    cn[ST_NUM].miss = cq[ST_DEN].miss || (dabs_c < DEN_LIM);
    cn[ST_NUM].dpos = !den[DEN_W-1] && (den != '0);
    cn[ST_OVF].miss = cq[ST_BIAS].miss || ovf_c;
    cn[ST_RNG].t    = t_c;
    cn[ST_RNG].miss = cq[ST_DIVL].miss || (t_c < $signed(cq[ST_DIVL].tmin))
                      || (t_c > $signed(cq[ST_DIVL].tmax));
    for (int k = 0; k < 3; k++) begin
      cn[ST_PNT].p[k] = P_W'(td[k] >>> F) + P_W'($signed(cq[ST_RNG].o[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= NS; s++) cq[s] <= cn[s];
    end
  end

  // Plane: denominator N.D, numerator (C-O).N.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd[k] <= nc[k] * $signed(cq[0].d[k]);
        co[k] <= CO_W'(cc[k]) - CO_W'($signed(cq[0].o[k]));
        pn[k] <= co[k] * nc[k];
      end
      den        <= DEN_W'(pd[0]) + DEN_W'(pd[1]) + DEN_W'(pd[2]);
      num        <= NUM_W'(pn[0]) + NUM_W'(pn[1]) + NUM_W'(pn[2]);
      dv[ST_NUM] <= dabs_c;
      dneg       <= den[DEN_W-1];
      // Fold the divisor sign into the dividend so the divisor is positive.
      nsh        <= dneg ? -(NSH_W'(num) <<< F) : (NSH_W'(num) <<< F);
      bias       <= BW'(nsh) + (BW'($signed({1'b0, dv[ST_NEG]})) <<< (CW-1));
      for (int s = ST_NEG; s <= ST_DIVL; s++) dv[s] <= dv[s-1];
      // Out of range quotients are a miss anyway; start from zero then.
      rem[ST_OVF] <= ovf_c ? '0 : RW'(bias);
      quo[ST_OVF] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= CW; j++) begin : g_div
    localparam int SB = CW - j;
    logic [RW:0] trial;
    assign trial = {1'b0, rem[ST_OVF+j-1]} - {1'b0, RW'(dv[ST_OVF+j-1]) << SB};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[ST_OVF+j] <= trial[RW] ? rem[ST_OVF+j-1] : trial[RW-1:0];
        quo[ST_OVF+j] <= quo[ST_OVF+j-1] | (CW'(!trial[RW]) << SB);
      end
    end
  end

  // Hit point, its offset from the corner, its Gram projections and edge test terms.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        td[k]   <= t_c * $signed(cq[ST_DIVL].d[k]);
        wvec[k] <= W_W'($signed(cq[ST_PNT].p[k])) - W_W'(cc[k]);
        wup[k]  <= wvec[k] * uc[k];
        wvp[k]  <= wvec[k] * vc[k];
      end
      wu <= WG_W'(wup[0]) + WG_W'(wup[1]) + WG_W'(wup[2]);
      wv <= WG_W'(wvp[0]) + WG_W'(wvp[1]) + WG_W'(wvp[2]);
      ipp[0] <= split_mul(uv, wv);
      ipp[1] <= split_mul(vv, wu);
      ipp[2] <= split_mul(uv, wu);
      ipp[3] <= split_mul(uu, wv);
      for (int j = 0; j < 4; j++) ipr[j] <= join_pp(ipp[j]);
      na  <= NA_W'(ipr[0]) - NA_W'(ipr[1]);
      nb  <= NA_W'(ipr[2]) - NA_W'(ipr[3]);
      det <= det_cfg;
      // Make the determinant positive; the numerators follow its sign.
      det_n <= det[NA_W-1] ? -det : det;
      na_n  <= det[NA_W-1] ? -na  : na;
      nb_n  <= det[NA_W-1] ? -nb  : nb;
    end
  end

  // ---------------------------------------------------------------- output stage
  logic                  o_hit;
  logic signed [CW-1:0]  o_t;
  logic signed [CW-1:0]  o_p [3];
  logic signed [CW-1:0]  o_n [3];
  logic [MAT_W-1:0]      o_mat;

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= !fmiss_c;
      o_t   <= fmiss_c ? '0 : $signed(cq[ST_NORM].t);
      o_mat <= fmiss_c ? '0 : material;
      for (int k = 0; k < 3; k++) begin
        o_p[k] <= fmiss_c ? '0 : sat_coord($signed(cq[ST_NORM].p[k]));
        if (fmiss_c) begin
          o_n[k] <= '0;
        end else if (cq[ST_NORM].dpos) begin
          o_n[k] <= (nc[k] == C_MIN) ? C_MAX : -nc[k];
        end else begin
          o_n[k] <= nc[k];
        end
      end
    end
  end

  assign m_tvalid = vld[NS];
  assign m_tuser  = o_hit;
  assign m_tdata  = DOUT_W'({o_mat, o_n[2], o_n[1], o_n[0], o_p[2], o_p[1], o_p[0], o_t});

endmodule

@@ rtl/rpi_checker.sv @@
// Port-level checker of the ray/parallelogram intersect unit, bound to the top level.
`timescale 1ns / 1ps
`include "ray_parallelogram_intersect_unit_macros.svh"
module rpi_checker
  import rpi_pkg::*;
#(
  parameter int COORD_WIDTH = 21
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     s_tvalid,
  input logic                                     s_tready,
  input logic                                     m_tvalid,
  input logic                                     m_tready,
  // hit_t, point_x, point_y, point_z, facing_nx, facing_ny, facing_nz, hit_material
  input logic [((7*COORD_WIDTH+MAT_W+7)/8)*8-1:0] m_tdata,
  // hit
  input logic [0:0]                               m_tuser,
  input logic                                     cfg_we,
  input logic [IDX_W-1:0]                         cfg_index,
  input logic [REG_W-1:0]                         cfg_data
);

  localparam int MAT_LSB = 7*COORD_WIDTH;

  // Shadow of the material register as seen on the write port.
  logic [MAT_W-1:0] mat_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_shadow <= '0;
    end else if (cfg_we && (cfg_index == REG_MATERIAL)) begin
      mat_shadow <= cfg_data[MAT_W-1:0];
    end
  end

  `RPI_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero data")
  `RPI_ASSERT_NOW(a_hit_mat, m_tvalid && m_tuser[0], m_tdata[MAT_LSB +: MAT_W] == mat_shadow, "hit carries wrong material")
  `RPI_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input held without output stall")
  `RPI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")

endmodule

bind ray_parallelogram_intersect_unit rpi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rpi_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

@@ dv/tb.sv @@
// Testbench of the ray/parallelogram intersect unit: directed rays, aimed and random rays.
`timescale 1ns / 1ps
module tb;
  import rpi_pkg::*;

  // Input item, first field in the lowest bits of s_tdata.
  typedef struct packed {
    logic signed [20:0] tmax;
    logic signed [20:0] tmin;
    logic signed [20:0] dz;
    logic signed [20:0] dy;
    logic signed [20:0] dx;
    logic signed [20:0] oz;
    logic signed [20:0] oy;
    logic signed [20:0] ox;
  } ray_t;

  // Result body as it sits in m_tdata, padded to whole bytes.
  typedef struct packed {
    logic [4:0]         pad;
    logic [7:0]         mat;
    logic signed [20:0] nz;
    logic signed [20:0] ny;
    logic signed [20:0] nx;
    logic signed [20:0] pz;
    logic signed [20:0] py;
    logic signed [20:0] px;
    logic signed [20:0] t;
  } hit_body_t;

  typedef struct packed {
    logic      hit;
    hit_body_t b;
  } hit_res_t;

  typedef struct {
    ray_t     r;
    bit       typed;
    hit_res_t res;
  } dir_row_t;

  // ceil(2^29 / 1e8) and ceil(2^28 / 5^12): raw parallel and degenerate limits.
  localparam longint PARALLEL_MIN = 6;
  localparam longint DEGEN_MIN    = 2;
  localparam longint C_MAX        = 1048575;
  localparam longint C_MIN        = -1048576;
  localparam int     LATENCY      = 37;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;   // hit_t, point_x/y/z, facing_nx/ny/nz, hit_material
  logic [0:0]   m_tuser;   // hit
  logic         cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  ray_parallelogram_intersect_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the quad registers.
  logic [62:0] corner_r, edge_u_r, edge_v_r, normal_r;
  logic [7:0]  material_r;

  hit_res_t pending_hits[$];
  int       mismatches;
  int       rays_sent;
  int       hits_seen;
  int       results_seen;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("ray_parallelogram_intersect_unit: mismatch");
    $finish;
  end

  function automatic longint comp(logic [62:0] v, int k);
    logic signed [20:0] f;
    f = v[21*k +: 21];
    return f;
  endfunction

  function automatic logic [62:0] pack3(longint x, longint y, longint z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  // Division rounding toward minus infinity.
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [127:0] wide(longint a);
    logic signed [127:0] w;
    w = a;
    return w;
  endfunction

  function automatic logic [20:0] sat21(longint v);
    longint s;
    s = v > C_MAX ? C_MAX : (v < C_MIN ? C_MIN : v);
    return s[20:0];
  endfunction

  // Expected outcome of one ray against the current quad.
  function automatic hit_res_t trace_ray(ray_t r);
    longint o[3], d[3], c[3], u[3], v[3], n[3], p[3], w[3], fn[3];
    longint den, num, t, uu, uv, vv, wu, wv, tmin, tmax;
    logic signed [127:0] det, na, nb;
    hit_res_t res;
    res = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    tmin = r.tmin;
    tmax = r.tmax;
    for (int k = 0; k < 3; k++) begin
      c[k] = comp(corner_r, k);
      u[k] = comp(edge_u_r, k);
      v[k] = comp(edge_v_r, k);
      n[k] = comp(normal_r, k);
    end
    den = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    if ((den < 0 ? -den : den) < PARALLEL_MIN) return res;
    num = (c[0]-o[0])*n[0] + (c[1]-o[1])*n[1] + (c[2]-o[2])*n[2];
    t = floor_div(num * 1024, den);
    if (t < tmin || t > tmax) return res;
    for (int k = 0; k < 3; k++) begin
      p[k] = o[k] + floor_div(t * d[k], 1024);
      w[k] = p[k] - c[k];
    end
    uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    wu = w[0]*u[0] + w[1]*u[1] + w[2]*u[2];
    wv = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
    det = wide(uv)*wide(uv) - wide(uu)*wide(vv);
    na  = wide(uv)*wide(wv) - wide(vv)*wide(wu);
    nb  = wide(uv)*wide(wu) - wide(uu)*wide(wv);
    if (det < 0) begin
      det = -det; na = -na; nb = -nb;
    end
    if (det < DEGEN_MIN) return res;
    if (na < 0 || nb < 0 || na > det || nb > det) return res;
    for (int k = 0; k < 3; k++) begin
      fn[k] = (den > 0) ? -n[k] : n[k];
      if (fn[k] > C_MAX) fn[k] = C_MAX;
    end
    res.hit   = 1'b1;
    res.b.t   = t[20:0];
    res.b.px  = sat21(p[0]);
    res.b.py  = sat21(p[1]);
    res.b.pz  = sat21(p[2]);
    res.b.nx  = fn[0][20:0];
    res.b.ny  = fn[1][20:0];
    res.b.nz  = fn[2][20:0];
    res.b.mat = material_r;
    return res;
  endfunction

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                                  longint dz, longint tmin, longint tmax);
    ray_t r;
    r.ox = ox[20:0]; r.oy = oy[20:0]; r.oz = oz[20:0];
    r.dx = dx[20:0]; r.dy = dy[20:0]; r.dz = dz[20:0];
    r.tmin = tmin[20:0]; r.tmax = tmax[20:0];
    return r;
  endfunction

  // Hit on the directed quad, normal along z.
  function automatic hit_res_t mk_hit(longint t, longint px, longint py, longint pz, longint nz);
    hit_res_t h;
    h = '0;
    h.hit = 1'b1;
    h.b.t = t[20:0]; h.b.px = px[20:0]; h.b.py = py[20:0]; h.b.pz = pz[20:0];
    h.b.nz = nz[20:0];
    h.b.mat = 8'hA5;
    return h;
  endfunction

  // Ray aimed at a point near the quad, with random direction and distance.
  function automatic ray_t aimed_ray();
    longint d[3], o[3], tgt, a, b, kk, tmin, tmax;
    if ($urandom_range(0, 9) == 0) begin
      a = longint'($urandom_range(0, 288)) - 16;
      b = longint'($urandom_range(0, 288)) - 16;
    end else begin
      a = $urandom_range(0, 256);
      b = $urandom_range(0, 256);
    end
    kk = $urandom_range(1, 24);
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'($urandom_range(0, 8192)) - 4096;
      tgt  = comp(corner_r, k) + (a*comp(edge_u_r, k) + b*comp(edge_v_r, k)) / 256;
      o[k] = tgt - kk * d[k];
    end
    tmin = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 30000)) - 2000 : 0;
    tmax = ($urandom_range(0, 3) == 0) ? kk*1024 + longint'($urandom_range(0, 64)) - 32 : C_MAX;
    return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2], tmin, tmax);
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  // Offer one item; hold tvalid high until it is taken.
  task automatic send_ray(ray_t r, bit typed, hit_res_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    pending_hits.push_back(typed ? res : trace_ray(r));
    rays_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [62:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CORNER:   corner_r   = val;
      REG_EDGE_U:   edge_u_r   = val;
      REG_EDGE_V:   edge_v_r   = val;
      REG_NORMAL:   normal_r   = val;
      REG_MATERIAL: material_r = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_quad(logic [62:0] c, logic [62:0] u, logic [62:0] v, logic [62:0] n,
                            logic [7:0] m);
    write_reg(REG_CORNER, c);
    write_reg(REG_EDGE_U, u);
    write_reg(REG_EDGE_V, v);
    write_reg(REG_NORMAL, n);
    write_reg(REG_MATERIAL, {55'd0, m});
    // let the Gram side pipeline settle on the new values
    repeat (8) @(posedge clk);
  endtask

  // Pick a quad for each random phase.
  task automatic setup_phase(int ph);
    longint u[3], v[3], cr[3];
    real len;
    case (ph)
      0: write_quad(pack3(longint'($urandom_range(0, 8000)) - 4000, -2000, 3000),
                    pack3($urandom_range(512, 8192), 0, 0),
                    pack3(0, $urandom_range(512, 8192), 0),
                    pack3(0, 0, ($urandom_range(0, 1) != 0) ? 524288 : -524288),
                    $urandom());
      // x-plane at the negative extreme, normal at -2^20 so the flip saturates
      1: write_quad(pack3(C_MIN, C_MIN + 1000, 0), pack3(0, C_MAX, 0),
                    pack3(0, 0, 900000), pack3(C_MIN, 0, 0), 8'hFF);
      2: begin
        for (int k = 0; k < 3; k++) begin
          u[k] = longint'($urandom_range(0, 8192)) - 4096;
          v[k] = longint'($urandom_range(0, 8192)) - 4096;
        end
        cr[0] = u[1]*v[2] - u[2]*v[1];
        cr[1] = u[2]*v[0] - u[0]*v[2];
        cr[2] = u[0]*v[1] - u[1]*v[0];
        len = $sqrt(real'(cr[0])**2 + real'(cr[1])**2 + real'(cr[2])**2);
        if (len == 0.0) begin
          cr[0] = 0; cr[1] = 0; cr[2] = 1; len = 1.0;
        end
        write_quad(pack3(1000, -3000, 500), pack3(u[0], u[1], u[2]), pack3(v[0], v[1], v[2]),
                   pack3($rtoi(cr[0]/len*524288.0), $rtoi(cr[1]/len*524288.0),
                         $rtoi(cr[2]/len*524288.0)), $urandom());
      end
      // degenerate: both edges the same
      3: write_quad(pack3(0, 0, 0), pack3(3000, 0, 0), pack3(3000, 0, 0),
                    pack3(0, 0, 524288), 8'h3C);
      4: write_quad({$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
      default: write_quad({63{1'b1}}, pack3(C_MAX, C_MAX, 0), pack3(0, C_MIN, C_MIN),
                          pack3(C_MAX, C_MAX, C_MAX), 8'h00);
    endcase
  endtask

  // Output side: random stall, long hold-off on request, check every accepted item.
  initial begin
    hit_res_t got;
    hit_res_t want;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.b   = m_tdata;
        got.b.pad = '0;
        results_seen++;
        if (got.hit) hits_seen++;
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = pending_hits.pop_front();
          if (got.hit !== want.hit || got.b.t !== want.b.t || got.b.px !== want.b.px ||
              got.b.py !== want.b.py || got.b.pz !== want.b.pz || got.b.nx !== want.b.nx ||
              got.b.ny !== want.b.ny || got.b.nz !== want.b.nz || got.b.mat !== want.b.mat) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d differs", results_seen);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    dir_row_t rows[16];
    hit_res_t miss;
    int idle_sets[4][2];
    miss = '0;
    idle_sets = '{'{0, 0}, '{56, 0}, '{0, 56}, '{31, 31}};
    mismatches = 0; rays_sent = 0; hits_seen = 0; results_seen = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
    corner_r = '0; edge_u_r = '0; edge_v_r = '0; normal_r = '0; material_r = '0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_index = REG_CORNER; cfg_data = '0;

    // Directed quad: corner (0,0,5), edges 4 along x and y, normal -z, tag A5.
    rows[0]  = '{mk_ray(0, 0, 0, 0, 0, 0, 0, 0), 1, miss};
    rows[1]  = '{mk_ray(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX), 1, miss};
    rows[2]  = '{mk_ray(2048, 2048, 0, 0, 0, 1024, 0, C_MAX), 1,
                 mk_hit(5120, 2048, 2048, 5120, -524288)};
    rows[3]  = '{mk_ray(2048, 2048, 0, 1024, 0, 0, 0, C_MAX), 1, miss};     // parallel
    rows[4]  = '{mk_ray(2048, 2048, 0, 0, 0, 1024, 0, 4096), 1, miss};      // beyond t_max
    rows[5]  = '{mk_ray(2048, 2048, 0, 0, 0, 1024, 8192, 0), 1, miss};      // inverted range
    rows[6]  = '{mk_ray(0, 0, 0, 0, 0, 1024, 0, C_MAX), 1,
                 mk_hit(5120, 0, 0, 5120, -524288)};                         // on the corner
    rows[7]  = '{mk_ray(4096, 4096, 0, 0, 0, 1024, 0, C_MAX), 1,
                 mk_hit(5120, 4096, 4096, 5120, -524288)};                   // far corner
    rows[8]  = '{mk_ray(4097, 2048, 0, 0, 0, 1024, 0, C_MAX), 1, miss};     // just outside
    rows[9]  = '{mk_ray(2048, 2048, 10240, 0, 0, -1024, 0, C_MAX), 1,
                 mk_hit(5120, 2048, 2048, 5120, 524288)};                    // normal flipped
    rows[10] = '{mk_ray(2048, 2048, 0, 0, 0, 1024, 5120, 5120), 1,
                 mk_hit(5120, 2048, 2048, 5120, -524288)};                   // t on both limits
    rows[11] = '{mk_ray(2048, 2048, 0, 0, 0, 3000, 0, C_MAX), 0, miss};
    rows[12] = '{mk_ray(2048, 2048, 0, C_MAX, C_MIN, 1024, C_MIN, C_MAX), 0, miss};
    rows[13] = '{mk_ray(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX), 0, miss};
    rows[14] = '{mk_ray(2048, 2048, 10240, 0, 0, 1024, C_MIN, C_MAX), 0, miss};
    rows[15] = '{mk_ray(1000, 3000, C_MAX, 3, -7, C_MIN, C_MIN, C_MAX), 0, miss};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: two rows against the reset quad, the rest against the directed one.
    foreach (rows[i]) begin
      if (i == 2) begin
        drain();
        write_quad(pack3(0, 0, 5120), pack3(4096, 0, 0), pack3(0, 4096, 0),
                   pack3(0, 0, -524288), 8'hA5);
      end
      send_ray(rows[i].r, rows[i].typed, rows[i].res);
    end
    drain();

    // Random part: six quads, idling patterns rotating between them.
    for (int ph = 0; ph < 6; ph++) begin
      setup_phase(ph);
      send_idle_pct  = idle_sets[ph % 4][0];
      recv_stall_pct = idle_sets[ph % 4][1];
      for (int i = 0; i < 90; i++) begin
        // back up the output and keep offering items until the input stalls
        if (ph == 0 && i == 20) hold_left = 150;
        // let the pipeline run dry mid-phase
        if (ph == 2 && i == 45) begin
          s_tvalid <= 1'b0;
          wait (pending_hits.size() == 0);
          @(posedge clk);
        end
        // quiet stretch with no idling on either side
        if (i == 60) begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        send_ray(($urandom_range(0, 9) < 7) ? aimed_ray() : noise_ray(), 0, miss);
      end
      drain();
    end

    $display("%0d rays over seven quads (reset, axis-aligned, extreme, tilted, degenerate,",
             rays_sent);
    $display("random, saturated), %0d hits among %0d results", hits_seen, results_seen);
    if (mismatches == 0) begin
      $display("ray_parallelogram_intersect_unit: match");
    end else begin
      $display("ray_parallelogram_intersect_unit: mismatch");
    end
    $finish;
  end

endmodule
